// ===== hdl/adll_pkg.sv =====
// Package for the array doubly linked list manager.
// Holds sizes, opcodes, status codes and the control struct; no dependencies.
package adll_pkg;
    localparam int Capacity = 16;
    localparam int SlotBits = 4;               // slot index width
    localparam int LinkBits = SlotBits + 1;    // link with null code
    localparam int KeyBits  = 32;
    localparam int CountBits = 5;
    localparam logic [LinkBits-1:0] Nil = LinkBits'(Capacity);

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_INS_BEFORE = 3'd1;
    localparam logic [2:0] OP_INS_AFTER = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_FIND = 3'd4;
    localparam logic [2:0] OP_READ = 3'd5;
    localparam logic [2:0] OP_HEAD = 3'd6;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // Memory write request from the sequencer to the slot store.
    typedef struct packed {
        logic                key_we;
        logic                next_we;
        logic                prev_we;
        logic [SlotBits-1:0] addr;
        logic [KeyBits-1:0]  key;
        logic [LinkBits-1:0] next;
        logic [LinkBits-1:0] prev;
    } t_wr;
endpackage

// ===== hdl/array_doubly_linked_list_manager_unit.sv =====
// Array doubly linked list manager: top level with the request sequencer.
// Depends on adll_pkg and adll_store.
// One request at a time. Reads, unused opcodes and failures at dispatch finish in S_RD; head
// reads its slot in S_SHOW/S_SHOWD; appends and inserts pass S_POS, S_FREE, S_W1-S_W3 and the
// show states; find walks the list, one slot-store read per step (at most 16), and delete adds
// S_W1-S_W3. The next request is taken once the result is registered; a result still waiting holds S_OUT.
// Reset: synchronous active low; list empty, free list is slots 0 to 15, no result valid.
module array_doubly_linked_list_manager_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // opcode[2:0], key[34:3], position[38:35]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // status, slot, found_key, next_slot,
                                       // has_next, prev_slot, has_prev, entry_count
);
    import adll_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_WALK = 4'd2,
        S_FREE = 4'd3, S_POS = 4'd4, S_W1 = 4'd5, S_W2 = 4'd6, S_W3 = 4'd7,
        S_SHOW = 4'd8, S_SHOWD = 4'd9, S_OUT = 4'd10;

    logic [3:0]          r_state;
    logic [2:0]          r_op;
    logic [KeyBits-1:0]  r_key;
    logic [SlotBits-1:0] r_pos;
    logic [LinkBits-1:0] r_head, r_tail, r_free, r_s, r_n, r_p, r_cur;
    logic [CountBits-1:0] r_count;
    logic [CountBits-1:0] r_steps;
    logic [Capacity-1:0] r_used;
    logic [55:0]         r_out;
    logic [55:0]         r_mdata;
    logic                r_ovld;
    logic [SlotBits-1:0] n_raddr;
    t_wr                 n_wr;
    logic [KeyBits-1:0]  m_key;
    logic [LinkBits-1:0] m_next, m_prev;

    adll_store u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_raddr(n_raddr), .i_wr(n_wr),
        .o_key(m_key), .o_next(m_next), .o_prev(m_prev)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_mdata;

    function automatic logic [55:0] pack(logic [1:0] st, logic [LinkBits-1:0] s,
        logic [KeyBits-1:0] k, logic [LinkBits-1:0] n, logic [LinkBits-1:0] p,
        logic [CountBits-1:0] c, logic show);
        logic [55:0] v;
        v = '0;
        v[1:0] = st;
        if (show) begin
            v[5:2]  = s[SlotBits-1:0];
            v[37:6] = k;
            if (n != Nil) begin v[41:38] = n[SlotBits-1:0]; v[42] = 1'b1; end
            if (p != Nil) begin v[46:43] = p[SlotBits-1:0]; v[47] = 1'b1; end
        end
        v[52:48] = c;
        return v;
    endfunction

    // Read address for the cycle; data returns next cycle.
    always_comb begin
        n_raddr = r_cur[SlotBits-1:0];
        n_wr = '0;
        unique case (r_state) inside
            S_IDLE: n_raddr = s_axis_tdata[38:35];
            S_WALK: n_raddr = m_next[SlotBits-1:0];
            S_SHOW, S_SHOWD: n_raddr = r_s[SlotBits-1:0];
            default: n_raddr = r_cur[SlotBits-1:0];
        endcase
        case (r_state)
            S_W1: begin
                // Write the new or removed slot.
                n_wr.addr = r_s[SlotBits-1:0];
                if (r_op == OP_DELETE) begin
                    n_wr.next_we = 1'b1; n_wr.next = r_free;
                end else begin
                    n_wr.key_we = 1'b1; n_wr.next_we = 1'b1; n_wr.prev_we = 1'b1;
                    n_wr.key = r_key; n_wr.next = r_n; n_wr.prev = r_p;
                end
            end
            S_W2: if (r_p != Nil) begin
                n_wr.addr = r_p[SlotBits-1:0]; n_wr.next_we = 1'b1;
                n_wr.next = (r_op == OP_DELETE) ? r_n : r_s;
            end
            S_W3: if (r_n != Nil) begin
                n_wr.addr = r_n[SlotBits-1:0]; n_wr.prev_we = 1'b1;
                n_wr.prev = (r_op == OP_DELETE) ? r_p : r_s;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovld <= 1'b0; r_head <= Nil; r_tail <= Nil;
            r_free <= '0; r_count <= '0; r_used <= '0;
        end else begin
            if (r_state == S_OUT && !r_ovld) r_ovld <= 1'b1;
            else if (r_ovld && m_axis_tready) r_ovld <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_op  <= s_axis_tdata[2:0];
                    r_key <= s_axis_tdata[34:3];
                    r_pos <= s_axis_tdata[38:35];
                    r_cur <= r_head;
                    r_steps <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    // Dispatch; the position slot's read data is valid now.
                    r_state <= S_OUT;
                    case (r_op) inside
                        OP_APPEND: if (r_free == Nil)
                            r_out <= pack(ST_FULL, '0, '0, Nil, Nil, r_count, 1'b0);
                        else begin
                            r_s <= r_free; r_n <= Nil; r_p <= r_tail;
                            r_cur <= r_free; r_state <= S_POS;
                        end
                        OP_INS_BEFORE, OP_INS_AFTER: if (!r_used[r_pos])
                            r_out <= pack(ST_BADPOS, '0, '0, Nil, Nil, r_count, 1'b0);
                        else if (r_free == Nil)
                            r_out <= pack(ST_FULL, '0, '0, Nil, Nil, r_count, 1'b0);
                        else begin
                            r_s <= r_free;
                            if (r_op == OP_INS_BEFORE) begin
                                r_n <= {1'b0, r_pos}; r_p <= m_prev;
                            end else begin
                                r_p <= {1'b0, r_pos}; r_n <= m_next;
                            end
                            r_cur <= r_free; r_state <= S_POS;
                        end
                        OP_DELETE, OP_FIND: if (r_head == Nil)
                            r_out <= pack(ST_MISS, '0, '0, Nil, Nil, r_count, 1'b0);
                        else r_state <= S_POS;
                        OP_READ: if (!r_used[r_pos])
                            r_out <= pack(ST_BADPOS, '0, '0, Nil, Nil, r_count, 1'b0);
                        else r_out <= pack(ST_OK, {1'b0, r_pos}, m_key, m_next,
                            m_prev, r_count, 1'b1);
                        OP_HEAD: if (r_head == Nil)
                            r_out <= pack(ST_MISS, '0, '0, Nil, Nil, r_count, 1'b0);
                        else begin r_s <= r_head; r_state <= S_SHOW; end
                        default: r_out <= pack(ST_OK, '0, '0, Nil, Nil, r_count, 1'b0);
                    endcase
                end
                S_POS: begin
                    // Appends and inserts: wait for free slot read. Search: head read lands.
                    if (r_op == OP_DELETE || r_op == OP_FIND) r_state <= S_WALK;
                    else r_state <= S_FREE;
                end
                S_WALK: begin
                    // m_* hold the slot r_cur.
                    if (m_key == r_key) begin
                        r_s <= r_cur; r_n <= m_next; r_p <= m_prev;
                        if (r_op == OP_FIND) begin
                            r_out <= pack(ST_OK, r_cur, m_key, m_next, m_prev,
                                r_count, 1'b1);
                            r_state <= S_OUT;
                        end else begin
                            r_out <= pack(ST_OK, r_cur, m_key, m_next, m_prev,
                                r_count - CountBits'(1), 1'b1);
                            r_state <= S_W1;
                        end
                    end else if (m_next == Nil || r_steps == CountBits'(Capacity - 1)) begin
                        r_out <= pack(ST_MISS, '0, '0, Nil, Nil, r_count, 1'b0);
                        r_state <= S_OUT;
                    end else begin
                        r_cur <= m_next; r_steps <= r_steps + CountBits'(1);
                    end
                end
                S_FREE: begin
                    // Free slot's next link gives the new free head.
                    r_free <= m_next;
                    r_used[r_s[SlotBits-1:0]] <= 1'b1;
                    r_count <= r_count + CountBits'(1);
                    if (r_p == Nil) r_head <= r_s;
                    if (r_n == Nil) r_tail <= r_s;
                    r_state <= S_W1;
                end
                S_W1: begin
                    if (r_op == OP_DELETE) begin
                        r_free <= r_s; r_used[r_s[SlotBits-1:0]] <= 1'b0;
                        r_count <= r_count - CountBits'(1);
                        if (r_p == Nil) r_head <= r_n;
                        if (r_n == Nil) r_tail <= r_p;
                    end
                    r_state <= S_W2;
                end
                S_W2: r_state <= S_W3;
                S_W3: r_state <= (r_op == OP_DELETE) ? S_OUT : S_SHOW;
                S_SHOW: r_state <= S_SHOWD;
                S_SHOWD: begin
                    r_out <= pack(ST_OK, r_s, m_key, m_next, m_prev, r_count, 1'b1);
                    r_state <= S_OUT;
                end
                // The result moves to the output register once the previous beat is gone.
                S_OUT: if (!r_ovld) begin
                    r_mdata <= r_out; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountBits'(Capacity))
        else $error("entry count beyond capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == Nil) == (r_count == '0))
        else $error("head and count disagree");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free == Nil) |-> (r_count == CountBits'(Capacity)))
        else $error("free list empty while slots remain");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !m_axis_tready) |=> r_ovld)
        else $error("result dropped");
endmodule

// ===== hdl/adll_store.sv =====
// Slot store: key, next and prev memories with registered read.
// Depends on adll_pkg. Next links reset to a chain by a valid-bit overlay.
module adll_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [adll_pkg::SlotBits-1:0] i_raddr,
    input  adll_pkg::t_wr             i_wr,
    output logic [adll_pkg::KeyBits-1:0]  o_key,
    output logic [adll_pkg::LinkBits-1:0] o_next,
    output logic [adll_pkg::LinkBits-1:0] o_prev
);
    import adll_pkg::*;

    logic [KeyBits-1:0]  r_key_mem  [Capacity];
    logic [LinkBits-1:0] r_next_mem [Capacity];
    logic [LinkBits-1:0] r_prev_mem [Capacity];
    logic [Capacity-1:0] r_next_vld;
    logic                r_rd_vld;
    logic [SlotBits-1:0] r_raddr;
    logic [LinkBits-1:0] r_next_raw;

    always_ff @(posedge i_clk) begin
        if (i_wr.key_we)  r_key_mem[i_wr.addr]  <= i_wr.key;
        if (i_wr.next_we) r_next_mem[i_wr.addr] <= i_wr.next;
        if (i_wr.prev_we) r_prev_mem[i_wr.addr] <= i_wr.prev;
        o_key      <= r_key_mem[i_raddr];
        r_next_raw <= r_next_mem[i_raddr];
        o_prev     <= r_prev_mem[i_raddr];
        r_raddr    <= i_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_wr.next_we) r_next_vld[i_wr.addr] <= 1'b1;
            r_rd_vld <= r_next_vld[i_raddr];
        end
    end

    // An unwritten next link reads as its reset value, the following slot.
    assign o_next = r_rd_vld ? r_next_raw : LinkBits'(r_raddr) + LinkBits'(1);
endmodule

// ===== tb/tb_array_doubly_linked_list_manager_unit.sv =====
// Testbench for the array doubly linked list manager: drives list requests on
// the input stream and checks every result beat against a behavioral list model.
// Depends on adll_pkg and the array_doubly_linked_list_manager_unit RTL.
`timescale 1ns / 1ps

import adll_pkg::*;

// Result fields from the highest bit down, as carried on m_axis_tdata.
typedef struct packed {
    logic [CountBits-1:0] entry_count;
    logic                 has_prev;
    logic [SlotBits-1:0]  prev_slot;
    logic                 has_next;
    logic [SlotBits-1:0]  next_slot;
    logic [KeyBits-1:0]   found_key;
    logic [SlotBits-1:0]  slot;
    logic [1:0]           status;
} t_list_result;

class list_scoreboard;
    logic [KeyBits-1:0]  keys [Capacity];
    logic [LinkBits-1:0] nxt [Capacity];
    logic [LinkBits-1:0] prv [Capacity];
    bit                  used [Capacity];
    logic [LinkBits-1:0] head, tail, free_head;
    int                  count;
    t_list_result        pending[$];
    int                  errors;
    int                  checked;
    int                  status_seen[4];

    function new();
        for (int i = 0; i < Capacity; i++) begin
            keys[i] = '0;
            prv[i] = '0;
            nxt[i] = LinkBits'(i + 1);
            used[i] = 0;
        end
        head = Nil;
        tail = Nil;
        free_head = '0;
        count = 0;
        errors = 0;
        checked = 0;
    endfunction

    function t_list_result describe(logic [1:0] st, logic [LinkBits-1:0] s, bit show);
        t_list_result        r;
        logic [SlotBits-1:0] si;
        r = '0;
        si = s[SlotBits-1:0];
        r.status = st;
        if (show && s < Nil) begin
            r.slot = si;
            r.found_key = keys[si];
            if (nxt[si] < Nil) begin
                r.next_slot = nxt[si][SlotBits-1:0];
                r.has_next = 1'b1;
            end
            if (prv[si] < Nil) begin
                r.prev_slot = prv[si][SlotBits-1:0];
                r.has_prev = 1'b1;
            end
        end
        r.entry_count = CountBits'(count);
        return r;
    endfunction

    function logic [LinkBits-1:0] search(logic [KeyBits-1:0] k);
        logic [LinkBits-1:0] i;
        int                  steps;
        i = head;
        steps = 0;
        while (i < Nil && steps < Capacity) begin
            if (keys[i[SlotBits-1:0]] == k) return i;
            i = nxt[i[SlotBits-1:0]];
            steps++;
        end
        return Nil;
    endfunction

    function logic [LinkBits-1:0] allocate(logic [KeyBits-1:0] k);
        logic [LinkBits-1:0] s;
        logic [SlotBits-1:0] si;
        s = free_head;
        si = s[SlotBits-1:0];
        free_head = nxt[si];
        keys[si] = k;
        used[si] = 1;
        count++;
        return s;
    endfunction

    // Applies one accepted request and queues the result it must produce.
    function void note_request(logic [2:0] op, logic [KeyBits-1:0] k,
                               logic [SlotBits-1:0] pos);
        logic [LinkBits-1:0] s, n, p;
        logic [SlotBits-1:0] si;
        t_list_result        r;
        case (op) inside
            OP_APPEND: begin
                if (free_head >= Nil) r = describe(ST_FULL, '0, 0);
                else begin
                    s = allocate(k);
                    si = s[SlotBits-1:0];
                    nxt[si] = Nil;
                    prv[si] = tail;
                    if (tail < Nil) nxt[tail[SlotBits-1:0]] = s;
                    else head = s;
                    tail = s;
                    r = describe(ST_OK, s, 1);
                end
            end
            OP_INS_BEFORE, OP_INS_AFTER: begin
                if (!used[pos]) r = describe(ST_BADPOS, '0, 0);
                else if (free_head >= Nil) r = describe(ST_FULL, '0, 0);
                else begin
                    s = allocate(k);
                    si = s[SlotBits-1:0];
                    if (op == OP_INS_BEFORE) begin
                        p = prv[pos];
                        nxt[si] = {1'b0, pos};
                        prv[si] = p;
                        if (p < Nil) nxt[p[SlotBits-1:0]] = s;
                        else head = s;
                        prv[pos] = s;
                    end else begin
                        n = nxt[pos];
                        prv[si] = {1'b0, pos};
                        nxt[si] = n;
                        if (n < Nil) prv[n[SlotBits-1:0]] = s;
                        else tail = s;
                        nxt[pos] = s;
                    end
                    r = describe(ST_OK, s, 1);
                end
            end
            OP_DELETE: begin
                s = search(k);
                if (s >= Nil) r = describe(ST_MISS, '0, 0);
                else begin
                    r = describe(ST_OK, s, 1);
                    si = s[SlotBits-1:0];
                    n = nxt[si];
                    p = prv[si];
                    if (p < Nil) nxt[p[SlotBits-1:0]] = n;
                    else head = n;
                    if (n < Nil) prv[n[SlotBits-1:0]] = p;
                    else tail = p;
                    used[si] = 0;
                    nxt[si] = free_head;
                    free_head = s;
                    count--;
                    r.entry_count = CountBits'(count);
                end
            end
            OP_FIND: begin
                s = search(k);
                r = (s >= Nil) ? describe(ST_MISS, '0, 0) : describe(ST_OK, s, 1);
            end
            OP_READ: r = used[pos] ? describe(ST_OK, {1'b0, pos}, 1)
                                   : describe(ST_BADPOS, '0, 0);
            OP_HEAD: r = (head >= Nil) ? describe(ST_MISS, '0, 0) : describe(ST_OK, head, 1);
            default: r = describe(ST_OK, '0, 0);
        endcase
        status_seen[r.status]++;
        pending.push_back(r);
    endfunction

    function void check_result(t_list_result got);
        t_list_result want;
        checked++;
        if (pending.size() == 0) begin
            $display("%0t: result beat with nothing outstanding: %p", $realtime, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status)
            report("status", KeyBits'(want.status), KeyBits'(got.status));
        if (got.slot !== want.slot)
            report("slot", KeyBits'(want.slot), KeyBits'(got.slot));
        if (got.found_key !== want.found_key)
            report("found_key", want.found_key, got.found_key);
        if (got.next_slot !== want.next_slot)
            report("next_slot", KeyBits'(want.next_slot), KeyBits'(got.next_slot));
        if (got.has_next !== want.has_next)
            report("has_next", KeyBits'(want.has_next), KeyBits'(got.has_next));
        if (got.prev_slot !== want.prev_slot)
            report("prev_slot", KeyBits'(want.prev_slot), KeyBits'(got.prev_slot));
        if (got.has_prev !== want.has_prev)
            report("has_prev", KeyBits'(want.has_prev), KeyBits'(got.has_prev));
        if (got.entry_count !== want.entry_count)
            report("entry_count", KeyBits'(want.entry_count), KeyBits'(got.entry_count));
    endfunction

    function void report(string field, logic [KeyBits-1:0] want, logic [KeyBits-1:0] got);
        $display("%0t: %s expected %0h actual %0h", $realtime, field, want, got);
        errors++;
    endfunction
endclass

module tb_array_doubly_linked_list_manager_unit;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;  // opcode, key, position
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;  // status, slot, found_key, next/has_next, prev/has_prev, count

    localparam int WatchdogLimit = 5000;

    list_scoreboard board;
    bit             calm;       // no idling on either side while set
    int             quiet_cycles = 0;
    int             sent;
    logic [KeyBits-1:0] key_pool[8];

    array_doubly_linked_list_manager_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Sends one request beat, idling first at random, and holds it until taken.
    // Valid stays up after the accepting edge; the next call or the end of the run lowers it.
    task automatic send_request(logic [2:0] op, logic [KeyBits-1:0] k, logic [SlotBits-1:0] pos);
        while (!calm && $urandom_range(99) < 21) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, pos, k, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_request(op, k, pos);
        sent++;
    endtask

    function automatic logic [KeyBits-1:0] pick_key();
        return ($urandom_range(3) != 0) ? key_pool[$urandom_range(7)] : $urandom();
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(t_list_result'(m_axis_tdata[52:0]));
            m_axis_tready <= calm || ($urandom_range(99) >= 21);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("Watchdog expired after %0d idle cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [2:0] op;
        int         roll;
        board = new();
        calm = 0;
        sent = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: head, find, delete, a read and an insert all fail; an unused opcode follows.
        send_request(OP_HEAD, '0, '0);
        send_request(OP_FIND, '1, '0);
        send_request(OP_DELETE, '0, '0);
        send_request(OP_READ, '0, 4'hF);
        send_request(OP_INS_BEFORE, 32'h1, 4'h0);
        send_request(3'd7, '1, 4'hF);
        // First append; inserts at both ends and mid-list; head query; middle and unused-slot reads.
        send_request(OP_APPEND, '0, '0);
        send_request(OP_INS_BEFORE, '1, 4'h0);
        send_request(OP_INS_AFTER, 32'hA5A5_5A5A, 4'h0);
        send_request(OP_INS_AFTER, 32'h5A5A_A5A5, 4'h0);
        send_request(OP_HEAD, '0, '0);
        send_request(OP_READ, '0, 4'h0);
        send_request(OP_READ, '0, 4'hF);
        // Fill the array, overflow on every insert flavor, then delete most entries again.
        for (int i = 0; i < 12; i++) send_request(OP_APPEND, 32'h100 + i, '0);
        send_request(OP_APPEND, '1, '0);
        send_request(OP_INS_AFTER, '1, 4'h3);
        send_request(OP_INS_BEFORE, '1, 4'hF);
        send_request(OP_DELETE, '1, '0);
        send_request(OP_DELETE, '0, '0);
        send_request(OP_FIND, 32'h10B, '0);
        for (int i = 0; i < 16; i++) send_request(OP_DELETE, 32'h100 + i, '0);

        // Random part: phases alternate growing and shrinking the list.
        for (int n = 0; n < 1800; n++) begin
            calm = (n >= 600 && n < 800);
            roll = $urandom_range(99);
            if (((n / 150) % 2) == 0)
                op = (roll < 35) ? OP_APPEND : (roll < 50) ? OP_INS_BEFORE :
                     (roll < 65) ? OP_INS_AFTER : (roll < 75) ? OP_DELETE :
                     3'($urandom_range(7));
            else
                op = (roll < 40) ? OP_DELETE : (roll < 55) ? OP_FIND :
                     (roll < 65) ? OP_APPEND : 3'($urandom_range(7));
            send_request(op, pick_key(), 4'($urandom_range(15)));
        end
        s_axis_tvalid <= 1'b0;
        calm = 0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Sent %0d requests, checked %0d results (ok %0d, full %0d, miss %0d, badpos %0d)",
                 sent, board.checked, board.status_seen[0], board.status_seen[1],
                 board.status_seen[2], board.status_seen[3]);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
